// ===== hw/rtl/cpkl_pkg.sv =====
`timescale 1ns / 1ps

package cpkl_pkg;

  localparam int KEY_W  = 16;
  localparam int KERN_W = 16;
  localparam int CNT_W  = 9;
  localparam int CMD_W  = 3;

  // Command codes carried by an input beat.
  localparam logic [CMD_W-1:0] CMD_WR_LEFT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_RIGHT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_CELL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CNT_LEFT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CNT_RIGHT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // One classified operation, as it travels from the front to the back.
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [1:0]              sub;
    logic [7:0]              slot;
    logic [KEY_W-1:0]        key;
    logic [3:0]              cls;
    logic [3:0]              col;
    logic signed [KERN_W-1:0] kern;
    logic [CNT_W-1:0]        cnt;
    logic [KEY_W-1:0]        left_glyph;
    logic [KEY_W-1:0]        right_glyph;
  } op_t;

endpackage

// ===== hw/rtl/class_pair_kern_lookup.sv =====
`timescale 1ns / 1ps
// A query leaves the queue and searches the active subtables in order: a binary
// search of the left map, on a hit one of the right map, then a grid read; at most
// 9 probes per map of 256 entries.
// The back end pops a beat only while idle, so a query holds later beats back until
// its done beat. Write and count beats apply when popped; two beats may wait queued.
// Reset (rst, synchronous) empties the queue, zeroes the map counts and the register.

module class_pair_kern_lookup #(
  parameter int SUBTABLES = 4,
  parameter int MAP_DEPTH = 256,
  parameter int CLASSES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [1:0]         subtable,
  input  logic [7:0]         slot,
  input  logic [15:0]        glyph_key,
  input  logic [3:0]         class_id,
  input  logic [3:0]         col_class,
  input  logic signed [15:0] kern_in,
  input  logic [8:0]         entry_count,
  input  logic [15:0]        left_glyph,
  input  logic [15:0]        right_glyph,
  output logic               done,
  output logic signed [15:0] kern_out,
  output logic               found,
  output logic [1:0]         matched_subtable
);
  import cpkl_pkg::*;

  logic [2:0] active_subtables;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  op_t        front_op;
  op_t        head_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_subtables <= '0;
    end else if (cfg_we) begin
      active_subtables <= cfg_data;
    end
  end

  assign busy = q_full;

  cpkl_front #(
    .SUBTABLES (SUBTABLES),
    .MAP_DEPTH (MAP_DEPTH),
    .CLASSES   (CLASSES)
  ) u_front (
    .start       (start),
    .full        (q_full),
    .cmd         (cmd),
    .subtable    (subtable),
    .slot        (slot),
    .glyph_key   (glyph_key),
    .class_id    (class_id),
    .col_class   (col_class),
    .kern_in     (kern_in),
    .entry_count (entry_count),
    .left_glyph  (left_glyph),
    .right_glyph (right_glyph),
    .push        (push),
    .op          (front_op)
  );

  cpkl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (front_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  cpkl_back #(
    .SUBTABLES (SUBTABLES),
    .MAP_DEPTH (MAP_DEPTH),
    .CLASSES   (CLASSES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .active_subtables (active_subtables),
    .q_empty          (q_empty),
    .q_op             (head_op),
    .pop              (pop),
    .done             (done),
    .kern_out         (kern_out),
    .found            (found),
    .matched_subtable (matched_subtable)
  );

endmodule

// ===== hw/rtl/cpkl_ram.sv =====
`timescale 1ns / 1ps

module cpkl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cpkl_front.sv =====
`timescale 1ns / 1ps

module cpkl_front #(
  parameter int SUBTABLES = 4,
  parameter int MAP_DEPTH = 256,
  parameter int CLASSES   = 16
) (
  input  logic                 start,
  input  logic                 full,
  input  logic [2:0]           cmd,
  input  logic [1:0]           subtable,
  input  logic [7:0]           slot,
  input  logic [15:0]          glyph_key,
  input  logic [3:0]           class_id,
  input  logic [3:0]           col_class,
  input  logic signed [15:0]   kern_in,
  input  logic [8:0]           entry_count,
  input  logic [15:0]          left_glyph,
  input  logic [15:0]          right_glyph,
  output logic                 push,
  output cpkl_pkg::op_t        op
);
  import cpkl_pkg::*;

  logic sub_ok;
  logic cls_ok;
  logic col_ok;
  logic slot_ok;
  logic keep;

  assign sub_ok  = int'(subtable) < SUBTABLES;
  assign cls_ok  = int'(class_id) < CLASSES;
  assign col_ok  = int'(col_class) < CLASSES;
  assign slot_ok = int'(slot) < MAP_DEPTH;

  // Items that would change nothing are dropped here and never queued.
  always_comb begin
    case (cmd)
      CMD_WR_LEFT, CMD_WR_RIGHT: keep = sub_ok && slot_ok && cls_ok;
      CMD_WR_CELL:               keep = sub_ok && cls_ok && col_ok;
      CMD_CNT_LEFT, CMD_CNT_RIGHT: keep = sub_ok;
      CMD_QUERY:                 keep = 1'b1;
      default:                   keep = 1'b0;
    endcase
  end

  always_comb begin
    op.cmd         = cmd;
    op.sub         = subtable;
    op.slot        = slot;
    op.key         = glyph_key;
    op.cls         = class_id;
    op.col         = col_class;
    op.kern        = kern_in;
    op.cnt         = (int'(entry_count) > MAP_DEPTH) ? CNT_W'(MAP_DEPTH) : entry_count;
    op.left_glyph  = left_glyph;
    op.right_glyph = right_glyph;
  end

  assign push = start && !full && keep;

endmodule

// ===== hw/rtl/cpkl_queue.sv =====
`timescale 1ns / 1ps

module cpkl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cpkl_pkg::op_t push_op,
  input  logic          pop,
  output cpkl_pkg::op_t head_op,
  output logic          empty,
  output logic          full
);
  import cpkl_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign empty   = (fill == '0);
  assign full    = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_op;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/cpkl_back.sv =====
`timescale 1ns / 1ps

module cpkl_back #(
  parameter int SUBTABLES = 4,
  parameter int MAP_DEPTH = 256,
  parameter int CLASSES   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           active_subtables,
  input  logic                 q_empty,
  input  cpkl_pkg::op_t        q_op,
  output logic                 pop,
  output logic                 done,
  output logic signed [15:0]   kern_out,
  output logic                 found,
  output logic [1:0]           matched_subtable
);
  import cpkl_pkg::*;

  localparam int SUB_W      = $clog2(SUBTABLES + 1);
  localparam int SIDX_W     = (SUBTABLES > 1) ? $clog2(SUBTABLES) : 1;
  localparam int CLS_W      = $clog2(CLASSES);
  localparam int MAP_WORDS  = SUBTABLES * MAP_DEPTH;
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int GRID_WORDS = SUBTABLES * CLASSES * CLASSES;
  localparam int GRID_AW    = $clog2(GRID_WORDS);
  localparam int ENT_W      = KEY_W + CLS_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LINIT  = 3'd1;
  localparam logic [2:0] ST_LPROBE = 3'd2;
  localparam logic [2:0] ST_LCMP   = 3'd3;
  localparam logic [2:0] ST_RPROBE = 3'd4;
  localparam logic [2:0] ST_RCMP   = 3'd5;
  localparam logic [2:0] ST_GRID   = 3'd6;

  logic [2:0]        state;
  logic [SUB_W-1:0]  sub;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi1;
  logic [CNT_W-1:0]  mid;
  logic [CLS_W-1:0]  lcls;
  logic [KEY_W-1:0]  lg;
  logic [KEY_W-1:0]  rg;
  logic [CNT_W-1:0]  lcount [SUBTABLES];
  logic [CNT_W-1:0]  rcount [SUBTABLES];

  logic [SIDX_W-1:0] sub_idx;
  logic [SUB_W-1:0]  n_active;
  logic [SUB_W:0]    sub_inc;
  logic              sub_last;
  logic [CNT_W:0]    span;
  logic [CNT_W-1:0]  mid_next;
  logic              probe_open;

  logic [MAP_AW-1:0]  map_raddr;
  logic [MAP_AW-1:0]  map_waddr;
  logic [GRID_AW-1:0] grid_raddr;
  logic [GRID_AW-1:0] grid_waddr;
  logic [ENT_W-1:0]   map_wdata;
  logic [ENT_W-1:0]   left_rd;
  logic [ENT_W-1:0]   right_rd;
  logic [KERN_W-1:0]  grid_rd;
  logic               left_we;
  logic               right_we;
  logic               grid_we;
  logic [KEY_W-1:0]   left_key;
  logic [KEY_W-1:0]   right_key;
  logic [CLS_W-1:0]   right_cls;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign sub_idx  = sub[SIDX_W-1:0];
  assign n_active = (int'(active_subtables) > SUBTABLES) ? SUB_W'(SUBTABLES)
                                                          : SUB_W'(active_subtables);
  assign sub_inc  = {1'b0, sub} + 1'b1;
  assign sub_last = (sub_inc >= {1'b0, n_active});

  // Probe point of the half-open window [lo, hi1), rounded down as the search defines.
  assign probe_open = (lo < hi1);
  assign span       = {1'b0, lo} + {1'b0, hi1} - (CNT_W + 1)'(1);
  assign mid_next   = span[CNT_W:1];

  assign left_key  = left_rd[ENT_W-1:CLS_W];
  assign right_key = right_rd[ENT_W-1:CLS_W];
  assign right_cls = right_rd[CLS_W-1:0];

  assign map_raddr  = MAP_AW'(int'(sub_idx) * MAP_DEPTH + int'(mid_next));
  assign grid_raddr = GRID_AW'((int'(sub_idx) * CLASSES + int'(lcls)) * CLASSES
                               + int'(right_cls));
  assign map_waddr  = MAP_AW'(int'(q_op.sub) * MAP_DEPTH + int'(q_op.slot));
  assign grid_waddr = GRID_AW'((int'(q_op.sub) * CLASSES + int'(q_op.cls)) * CLASSES
                               + int'(q_op.col));
  assign map_wdata  = {q_op.key, CLS_W'(q_op.cls)};

  assign left_we  = pop && (q_op.cmd == CMD_WR_LEFT);
  assign right_we = pop && (q_op.cmd == CMD_WR_RIGHT);
  assign grid_we  = pop && (q_op.cmd == CMD_WR_CELL);

  cpkl_ram #(.WIDTH(ENT_W), .DEPTH(MAP_WORDS)) u_left_map (
    .clk   (clk),
    .we    (left_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (left_rd)
  );

  cpkl_ram #(.WIDTH(ENT_W), .DEPTH(MAP_WORDS)) u_right_map (
    .clk   (clk),
    .we    (right_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (right_rd)
  );

  cpkl_ram #(.WIDTH(KERN_W), .DEPTH(GRID_WORDS)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (q_op.kern),
    .raddr (grid_raddr),
    .rdata (grid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < SUBTABLES; i++) begin
        lcount[i] <= '0;
        rcount[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (q_op.cmd)
              CMD_CNT_LEFT:  lcount[SIDX_W'(q_op.sub)] <= q_op.cnt;
              CMD_CNT_RIGHT: rcount[SIDX_W'(q_op.sub)] <= q_op.cnt;
              CMD_QUERY: begin
                lg  <= q_op.left_glyph;
                rg  <= q_op.right_glyph;
                sub <= '0;
                if (n_active == '0) begin
                  done             <= 1'b1;
                  kern_out         <= '0;
                  found            <= 1'b0;
                  matched_subtable <= '0;
                end else begin
                  state <= ST_LINIT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LINIT: begin
          lo    <= '0;
          hi1   <= lcount[sub_idx];
          state <= ST_LPROBE;
        end
        ST_LPROBE, ST_RPROBE: begin
          if (probe_open) begin
            mid   <= mid_next;
            state <= (state == ST_LPROBE) ? ST_LCMP : ST_RCMP;
          end else if (sub_last) begin
            // No subtable left to try: report a miss.
            done             <= 1'b1;
            kern_out         <= '0;
            found            <= 1'b0;
            matched_subtable <= '0;
            state            <= ST_IDLE;
          end else begin
            sub   <= sub_inc[SUB_W-1:0];
            state <= ST_LINIT;
          end
        end
        ST_LCMP: begin
          if (left_key == lg) begin
            lcls  <= left_rd[CLS_W-1:0];
            lo    <= '0;
            hi1   <= rcount[sub_idx];
            state <= ST_RPROBE;
          end else begin
            if (left_key < lg) begin
              lo <= mid + 1'b1;
            end else begin
              hi1 <= mid;
            end
            state <= ST_LPROBE;
          end
        end
        ST_RCMP: begin
          // On a hit the grid read is issued this cycle from the right class.
          if (right_key == rg) begin
            state <= ST_GRID;
          end else begin
            if (right_key < rg) begin
              lo <= mid + 1'b1;
            end else begin
              hi1 <= mid;
            end
            state <= ST_RPROBE;
          end
        end
        ST_GRID: begin
          done             <= 1'b1;
          kern_out         <= grid_rd;
          found            <= 1'b1;
          matched_subtable <= 2'(sub);
          state            <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cpkl_checker.sv =====
`timescale 1ns / 1ps

module cpkl_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] kern_out,
  input logic               found,
  input logic [1:0]         matched_subtable
);

  // Nothing is reported or held back in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy high straight after reset");

  // A miss carries a zero value and subtable zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> kern_out == 16'sd0 && matched_subtable == 2'd0)
    else $error("miss beat with non-zero payload");

  // The queue only fills because a beat was taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted beat");

  // While the queue is full and no beat is offered, busy does not rise again.
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> !$rose(busy))
    else $error("busy rose again without a new beat");

endmodule

bind class_pair_kern_lookup cpkl_checker u_cpkl_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .kern_out         (kern_out),
  .found            (found),
  .matched_subtable (matched_subtable)
);

// ===== tb/sv/kern_lookup_checker.sv =====
`timescale 1ns / 1ps

module kern_lookup_checker #(
  parameter int SUBTABLES = 4,
  parameter int MAP_DEPTH = 256,
  parameter int CLASSES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         cmd,
  input  logic [1:0]         subtable,
  input  logic [7:0]         slot,
  input  logic [15:0]        glyph_key,
  input  logic [3:0]         class_id,
  input  logic [3:0]         col_class,
  input  logic signed [15:0] kern_in,
  input  logic [8:0]         entry_count,
  input  logic [15:0]        left_glyph,
  input  logic [15:0]        right_glyph,
  input  logic               done,
  input  logic signed [15:0] kern_out,
  input  logic               found,
  input  logic [1:0]         matched_subtable,
  output int                 fail_count,
  output int                 pending
);
  import cpkl_pkg::*;

  typedef struct packed {
    logic signed [KERN_W-1:0] kern;
    logic                     hit;
    logic [1:0]               sub;
  } kern_answer_t;

  logic [KEY_W-1:0]         left_key   [SUBTABLES][MAP_DEPTH];
  logic [3:0]               left_cls   [SUBTABLES][MAP_DEPTH];
  logic [KEY_W-1:0]         right_key  [SUBTABLES][MAP_DEPTH];
  logic [3:0]               right_cls  [SUBTABLES][MAP_DEPTH];
  logic signed [KERN_W-1:0] kern_grid  [SUBTABLES][CLASSES][CLASSES];
  int                       left_count [SUBTABLES];
  int                       right_count[SUBTABLES];
  logic [2:0]               active;

  kern_answer_t expected_kerns[$];
  kern_answer_t want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  // Plain binary search; with unsorted keys it simply follows the same probes.
  function automatic int map_find(input bit right_map, input int s, input int count,
                                  input logic [KEY_W-1:0] glyph);
    int lo, hi, mid;
    logic [KEY_W-1:0] k;
    lo = 0;
    hi = count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      k = right_map ? right_key[s][mid] : left_key[s][mid];
      if (k == glyph) return mid;
      if (k < glyph) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic kern_answer_t predict_kern(input logic [KEY_W-1:0] lg,
                                                input logic [KEY_W-1:0] rg);
    kern_answer_t res;
    int n, li, ri;
    res = '0;
    n = (int'(active) > SUBTABLES) ? SUBTABLES : int'(active);
    for (int s = 0; s < n; s++) begin
      li = map_find(1'b0, s, left_count[s], lg);
      if (li < 0) continue;
      ri = map_find(1'b1, s, right_count[s], rg);
      if (ri < 0) continue;
      res.kern = kern_grid[s][left_cls[s][li]][right_cls[s][ri]];
      res.hit  = 1'b1;
      res.sub  = 2'(s);
      return res;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SUBTABLES; s++) begin
        left_count[s]  = 0;
        right_count[s] = 0;
      end
      active = '0;
      expected_kerns.delete();
    end else begin
      if (cfg_we) active = cfg_data;
      if (done) begin
        if (expected_kerns.size() == 0) begin
          report_mismatch("result with no query outstanding", int'(kern_out), 0);
        end else begin
          want = expected_kerns.pop_front();
          if (found !== want.hit)
            report_mismatch("found", int'(found), int'(want.hit));
          if (matched_subtable !== want.sub)
            report_mismatch("matched_subtable", int'(matched_subtable), int'(want.sub));
          if (kern_out !== want.kern)
            report_mismatch("kern_out", int'(kern_out), int'($signed(want.kern)));
        end
      end
      if (start && !busy) begin
        case (cmd)
          CMD_WR_LEFT: begin
            left_key[subtable][slot] = glyph_key;
            left_cls[subtable][slot] = class_id;
          end
          CMD_WR_RIGHT: begin
            right_key[subtable][slot] = glyph_key;
            right_cls[subtable][slot] = class_id;
          end
          CMD_WR_CELL: kern_grid[subtable][class_id][col_class] = kern_in;
          CMD_CNT_LEFT:
            left_count[subtable] = (entry_count > MAP_DEPTH) ? MAP_DEPTH : int'(entry_count);
          CMD_CNT_RIGHT:
            right_count[subtable] = (entry_count > MAP_DEPTH) ? MAP_DEPTH : int'(entry_count);
          CMD_QUERY: expected_kerns.push_back(predict_kern(left_glyph, right_glyph));
          default: ;
        endcase
      end
    end
    pending <= expected_kerns.size();
  end

endmodule

// ===== tb/sv/tb_class_pair_kern_lookup.sv =====
`timescale 1ns / 1ps

module tb_class_pair_kern_lookup;
  import cpkl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_IGNORED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_IGNORED_7 = 3'd7;
  localparam bit LEFT  = 1'b0;
  localparam bit RIGHT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [1:0]        sub;
    logic [7:0]        slot;
    logic [KEY_W-1:0]  key;
    logic [3:0]        cls;
    logic [3:0]        col;
    logic [KERN_W-1:0] kern;
    logic [CNT_W-1:0]  cnt;
    logic [KEY_W-1:0]  lg;
    logic [KEY_W-1:0]  rg;
  } kern_cmd_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_data;
  logic               start;
  logic               busy;
  logic [2:0]         cmd;
  logic [1:0]         subtable;
  logic [7:0]         slot;
  logic [15:0]        glyph_key;
  logic [3:0]         class_id;
  logic [3:0]         col_class;
  logic signed [15:0] kern_in;
  logic [8:0]         entry_count;
  logic [15:0]        left_glyph;
  logic [15:0]        right_glyph;
  logic               done;
  logic signed [15:0] kern_out;
  logic               found;
  logic [1:0]         matched_subtable;
  int                 fail_count;
  int                 pending;

  // Keys held in each map, and the classes each subtable's maps draw from,
  // so that every grid cell a query can reach has been written.
  logic [15:0] lkey_shadow [4][256];
  logic [15:0] rkey_shadow [4][256];
  logic [3:0]  lset [4][3];
  logic [3:0]  rset [4][3];
  int          lset_n [4];
  int          rset_n [4];
  int          lfill [4];
  int          rfill [4];
  int          idle_pct;

  class_pair_kern_lookup uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .cmd(cmd), .subtable(subtable), .slot(slot),
    .glyph_key(glyph_key), .class_id(class_id), .col_class(col_class),
    .kern_in(kern_in), .entry_count(entry_count), .left_glyph(left_glyph),
    .right_glyph(right_glyph), .done(done), .kern_out(kern_out), .found(found),
    .matched_subtable(matched_subtable)
  );

  kern_lookup_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .cmd(cmd), .subtable(subtable), .slot(slot),
    .glyph_key(glyph_key), .class_id(class_id), .col_class(col_class),
    .kern_in(kern_in), .entry_count(entry_count), .left_glyph(left_glyph),
    .right_glyph(right_glyph), .done(done), .kern_out(kern_out), .found(found),
    .matched_subtable(matched_subtable), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic kern_cmd_t noise_beat();
    kern_cmd_t b;
    b.op   = CMD_QUERY;
    b.sub  = 2'($urandom_range(0, 3));
    b.slot = 8'($urandom_range(0, 255));
    b.key  = 16'($urandom_range(0, 65535));
    b.cls  = 4'($urandom_range(0, 15));
    b.col  = 4'($urandom_range(0, 15));
    b.kern = 16'($urandom_range(0, 65535));
    b.cnt  = 9'($urandom_range(0, 511));
    b.lg   = 16'($urandom_range(0, 65535));
    b.rg   = 16'($urandom_range(0, 65535));
    return b;
  endfunction

  task automatic send_beat(input kern_cmd_t b);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= b.op;
    subtable    <= b.sub;
    slot        <= b.slot;
    glyph_key   <= b.key;
    class_id    <= b.cls;
    col_class   <= b.col;
    kern_in     <= b.kern;
    entry_count <= b.cnt;
    left_glyph  <= b.lg;
    right_glyph <= b.rg;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The checker's count is registered, so the task waits on the clock before looking.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_active(input logic [2:0] v);
    drain_results();
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic put_entry(input bit side, input int s, input int pos,
                           input logic [15:0] key, input logic [3:0] cls);
    kern_cmd_t b;
    b = noise_beat();
    b.op   = (side == RIGHT) ? CMD_WR_RIGHT : CMD_WR_LEFT;
    b.sub  = 2'(s);
    b.slot = 8'(pos);
    b.key  = key;
    b.cls  = cls;
    if (side == RIGHT) rkey_shadow[s][pos] = key;
    else lkey_shadow[s][pos] = key;
    send_beat(b);
  endtask

  task automatic put_cell(input int s, input logic [3:0] row, input logic [3:0] col,
                          input logic signed [15:0] kv);
    kern_cmd_t b;
    b = noise_beat();
    b.op   = CMD_WR_CELL;
    b.sub  = 2'(s);
    b.cls  = row;
    b.col  = col;
    b.kern = kv;
    send_beat(b);
  endtask

  task automatic put_count(input bit side, input int s, input int n);
    kern_cmd_t b;
    b = noise_beat();
    b.op  = (side == RIGHT) ? CMD_CNT_RIGHT : CMD_CNT_LEFT;
    b.sub = 2'(s);
    b.cnt = 9'(n);
    send_beat(b);
  endtask

  task automatic ask(input logic [15:0] lg, input logic [15:0] rg);
    kern_cmd_t b;
    b = noise_beat();
    b.op = CMD_QUERY;
    b.lg = lg;
    b.rg = rg;
    send_beat(b);
  endtask

  // Ascending, distinct keys that stay within the glyph range.
  task automatic fill_map(input bit side, input int s, input int n);
    int gap, key;
    logic [3:0] cls;
    gap = 65535 / (n + 1);
    if (gap > 9000) gap = 9000;
    key = $urandom_range(0, gap - 1);
    for (int k = 0; k < n; k++) begin
      if (side == RIGHT) cls = rset[s][$urandom_range(0, rset_n[s] - 1)];
      else cls = lset[s][$urandom_range(0, lset_n[s] - 1)];
      put_entry(side, s, k, 16'(key), cls);
      key += $urandom_range(1, gap);
    end
  endtask

  task automatic load_subtable(input int s, input int nl, input int nr);
    logic signed [15:0] kv;
    lset_n[s] = $urandom_range(1, 3);
    rset_n[s] = $urandom_range(1, 3);
    for (int k = 0; k < 3; k++) begin
      lset[s][k] = 4'($urandom_range(0, 15));
      rset[s][k] = 4'($urandom_range(0, 15));
    end
    fill_map(LEFT, s, nl);
    fill_map(RIGHT, s, nr);
    for (int i = 0; i < lset_n[s]; i++) begin
      for (int j = 0; j < rset_n[s]; j++) begin
        kv = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 5) == 0) kv = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        put_cell(s, lset[s][i], rset[s][j], kv);
      end
    end
    // A full map is sometimes given an oversized count, which must saturate.
    if (nl == 256 && $urandom_range(0, 1) == 1) put_count(LEFT, s, $urandom_range(256, 511));
    else put_count(LEFT, s, nl);
    put_count(RIGHT, s, nr);
    lfill[s] = nl;
    rfill[s] = nr;
  endtask

  task automatic random_item();
    kern_cmd_t b;
    int s, r, fill, pos, n;
    bit side;
    logic [3:0] cls;
    b = noise_beat();
    s = b.sub;
    side = 1'($urandom_range(0, 1));
    fill = (side == RIGHT) ? rfill[s] : lfill[s];
    r = $urandom_range(1, 100);
    if (r <= 55) begin
      b.op = CMD_QUERY;
      if (lfill[s] > 0 && $urandom_range(0, 4) != 0)
        b.lg = lkey_shadow[s][$urandom_range(0, lfill[s] - 1)];
      if (rfill[s] > 0 && $urandom_range(0, 4) != 0)
        b.rg = rkey_shadow[s][$urandom_range(0, rfill[s] - 1)];
      if ($urandom_range(0, 19) == 0) b.lg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(0, 19) == 0) b.rg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      send_beat(b);
    end else if (r <= 68) begin
      b.op = CMD_WR_CELL;
      send_beat(b);
    end else if (r <= 86) begin
      // Inside the searched part a random key may break the ordering, but the
      // class stays within the set whose grid cells are written.
      if (fill > 0 && (fill == 256 || $urandom_range(0, 1) == 1)) begin
        pos = $urandom_range(0, fill - 1);
        if (side == RIGHT) cls = rset[s][$urandom_range(0, rset_n[s] - 1)];
        else cls = lset[s][$urandom_range(0, lset_n[s] - 1)];
      end else begin
        pos = $urandom_range(fill, 255);
        cls = b.cls;
      end
      put_entry(side, s, pos, b.key, cls);
    end else if (r <= 95) begin
      n = $urandom_range(0, fill);
      if (fill == 256 && $urandom_range(0, 1) == 1) n = $urandom_range(256, 511);
      put_count(side, s, n);
    end else begin
      b.op = $urandom_range(0, 1) ? CMD_IGNORED_7 : CMD_IGNORED_6;
      send_beat(b);
    end
  endtask

  initial begin
    int plan [9];
    kern_cmd_t b;
    plan = '{4, 2, 7, 1, 3, 5, 6, 0, 4};
    for (int s = 0; s < 4; s++) begin
      lfill[s]  = 0;
      rfill[s]  = 0;
      lset_n[s] = 1;
      rset_n[s] = 1;
    end
    idle_pct    = 25;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_data    <= '0;
    start       <= 1'b0;
    cmd         <= '0;
    subtable    <= '0;
    slot        <= '0;
    glyph_key   <= '0;
    class_id    <= '0;
    col_class   <= '0;
    kern_in     <= '0;
    entry_count <= '0;
    left_glyph  <= '0;
    right_glyph <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the register at zero nothing is searched.
    ask(16'h0000, 16'hFFFF);
    b = noise_beat();
    b.op = CMD_IGNORED_6;
    send_beat(b);
    b = noise_beat();
    b.op = CMD_IGNORED_7;
    send_beat(b);

    lset[0][0] = 4'd15;
    rset[0][0] = 4'd0;
    put_entry(LEFT, 0, 0, 16'h0000, 4'd15);
    put_entry(RIGHT, 0, 0, 16'hFFFF, 4'd0);
    put_cell(0, 4'd15, 4'd0, 16'sh8000);
    put_count(LEFT, 0, 1);
    put_count(RIGHT, 0, 1);
    lfill[0] = 1;
    rfill[0] = 1;
    ask(16'h0000, 16'hFFFF);

    write_active(3'd1);
    ask(16'h0000, 16'hFFFF);
    ask(16'h0000, 16'h0000);
    ask(16'h0001, 16'hFFFF);
    put_cell(0, 4'd15, 4'd0, 16'sh7FFF);
    ask(16'h0000, 16'hFFFF);
    put_count(LEFT, 0, 0);
    ask(16'h0000, 16'hFFFF);
    put_count(LEFT, 0, 1);

    // The same pair in a later subtable: the earlier one wins while it holds both.
    lset[1][0] = 4'd0;
    rset[1][0] = 4'd15;
    put_entry(LEFT, 1, 0, 16'h0000, 4'd0);
    put_entry(RIGHT, 1, 0, 16'hFFFF, 4'd15);
    put_cell(1, 4'd0, 4'd15, 16'sd1);
    put_count(LEFT, 1, 1);
    put_count(RIGHT, 1, 1);
    lfill[1] = 1;
    rfill[1] = 1;
    write_active(3'd7);
    ask(16'h0000, 16'hFFFF);
    put_count(LEFT, 0, 0);
    ask(16'h0000, 16'hFFFF);

    for (int s = 0; s < 4; s++) load_subtable(s, $urandom_range(1, 12), $urandom_range(1, 12));

    for (int p = 0; p < 9; p++) begin
      write_active(3'(plan[p]));
      idle_pct = (p == 8 || p % 3 == 1) ? 0 : 30;
      if (p == 3) load_subtable($urandom_range(0, 3), 256, $urandom_range(1, 12));
      else if (p > 0)
        load_subtable($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(0, 12));
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(0, 79) == 0) drain_results();
        random_item();
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
